// ----- hdl/ihq_pkg.sv -----
// Shared constants for the indexed min-heap queue.
// No dependencies.
`default_nettype none
package ihq_pkg;
	localparam int HEAP_SLOTS_DEF  = 256;
	localparam int ID_WIDTH_DEF    = 10;
	localparam int KEY_W           = 32;
	localparam int DATA_W          = 32;
	localparam int CFG_W           = 9;
	localparam int LIMIT_WHEN_ZERO = 100;
	localparam int CAP_RESET       = 256;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_CHANGE = 2'd1;
	localparam logic [1:0] REQ_POP    = 2'd2;
	localparam logic [1:0] REQ_REMOVE = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_EXISTS    = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_EMPTY     = 3'd4;
endpackage
`default_nettype wire

// ----- hdl/ihq_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
// Depends on nothing.
`default_nettype none
module ihq_ram #(
	parameter int WIDTH = 8,
	parameter int AW    = 8
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- hdl/indexed_min_heap_queue_core.sv -----
// Indexed min-heap queue: request sequencer around a heap RAM and an id-to-slot RAM.
// Depends on ihq_pkg and ihq_ram.
//
//  channel  | handshake           | fields
//  request  | in_valid / in_stall | req_type, item_id, item_key, item_data
//  result   | out_valid/out_stall | status, out_id, out_key, out_data
//  config   | cfg_we              | cfg_wdata (capacity_limit)
//
// One request at a time: lookup and removal, then sift up or sift down level by level,
// paced by the single read port of the heap RAM, then write back and reply.
// No clearing pass after reset: a map entry is trusted only if its slot lies inside
// the heap and holds the same id.
// A result waits in the output register while the next request is taken; a second
// result waits in the reply state with the input stalled.
`default_nettype none
module indexed_min_heap_queue_core #(
	parameter int HEAP_SLOTS = ihq_pkg::HEAP_SLOTS_DEF,
	parameter int ID_WIDTH   = ihq_pkg::ID_WIDTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [1:0]                  req_type,
	input  wire logic [ID_WIDTH-1:0]         item_id,
	input  wire logic [ihq_pkg::KEY_W-1:0]   item_key,
	input  wire logic [ihq_pkg::DATA_W-1:0]  item_data,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [2:0]                       status,
	output logic [ID_WIDTH-1:0]              out_id,
	output logic [ihq_pkg::KEY_W-1:0]        out_key,
	output logic [ihq_pkg::DATA_W-1:0]       out_data,
	input  wire logic                        cfg_we,
	input  wire logic [ihq_pkg::CFG_W-1:0]   cfg_wdata
);
	import ihq_pkg::*;

	localparam int SW = $clog2(HEAP_SLOTS + 1);
	localparam int AW = $clog2(HEAP_SLOTS);
	localparam int LW = (SW > CFG_W) ? SW : CFG_W;
	localparam int EW = ID_WIDTH + KEY_W + DATA_W;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MAP   = 4'd1;
	localparam logic [3:0] S_CHK   = 4'd2;
	localparam logic [3:0] S_TAKE  = 4'd3;
	localparam logic [3:0] S_LAST  = 4'd4;
	localparam logic [3:0] S_UP    = 4'd5;
	localparam logic [3:0] S_UPC   = 4'd6;
	localparam logic [3:0] S_DN    = 4'd7;
	localparam logic [3:0] S_DNL   = 4'd8;
	localparam logic [3:0] S_DNR   = 4'd9;
	localparam logic [3:0] S_FIN   = 4'd10;
	localparam logic [3:0] S_REPLY = 4'd11;

	logic [3:0]          state_q;
	logic [1:0]          req_q;
	logic [ID_WIDTH-1:0] id_q;
	logic [KEY_W-1:0]    key_q;
	logic [DATA_W-1:0]   data_q;
	logic [SW-1:0]       count_q;
	logic [CFG_W-1:0]    cap_q;
	logic [SW-1:0]       p_q;
	logic [ID_WIDTH-1:0] cur_id_q;
	logic [KEY_W-1:0]    cur_key_q;
	logic [DATA_W-1:0]   cur_data_q;
	logic [EW-1:0]       lft_q;
	logic [KEY_W-1:0]    gone_key_q;
	logic [2:0]          res_st_q;
	logic [ID_WIDTH-1:0] res_id_q;
	logic [KEY_W-1:0]    res_key_q;
	logic [DATA_W-1:0]   res_data_q;
	logic                out_valid_q;
	logic [2:0]          status_q;
	logic [ID_WIDTH-1:0] out_id_q;
	logic [KEY_W-1:0]    out_key_q;
	logic [DATA_W-1:0]   out_data_q;

	logic                h_we;
	logic [AW-1:0]       h_waddr, h_raddr;
	logic [EW-1:0]       h_wdata, h_rdata;
	logic                m_we;
	logic [ID_WIDTH-1:0] m_waddr, m_raddr;
	logic [SW-1:0]       m_wdata, m_rdata;

	ihq_ram #(.WIDTH(EW), .AW(AW)) u_heap (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.raddr(h_raddr), .rdata(h_rdata)
	);

	ihq_ram #(.WIDTH(SW), .AW(ID_WIDTH)) u_map (
		.clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
		.raddr(m_raddr), .rdata(m_rdata)
	);

	logic [ID_WIDTH-1:0] h_id;
	logic [KEY_W-1:0]    h_key;
	logic [DATA_W-1:0]   h_data;
	assign h_id   = h_rdata[EW-1 -: ID_WIDTH];
	assign h_key  = h_rdata[KEY_W+DATA_W-1 -: KEY_W];
	assign h_data = h_rdata[DATA_W-1:0];

	logic [LW-1:0] lim_raw, lim, count_ext;
	assign lim_raw   = (cap_q == '0) ? LW'(LIMIT_WHEN_ZERO) : LW'(cap_q);
	assign lim       = (lim_raw > LW'(HEAP_SLOTS)) ? LW'(HEAP_SLOTS) : lim_raw;
	assign count_ext = LW'(count_q);

	logic [SW:0]   l_pos, r_pos;
	logic          map_ok, hit;
	logic [EW-1:0] t_ent;
	logic [SW-1:0] t_pos;
	logic          t_less;
	logic          reply_go;

	assign l_pos  = {p_q, 1'b0};
	assign r_pos  = l_pos + 1'b1;
	assign map_ok = (m_rdata != '0) && (m_rdata <= count_q);
	assign hit    = (h_id == id_q);

	always_comb begin
		if (state_q == S_DNR && !($signed(lft_q[KEY_W+DATA_W-1 -: KEY_W]) < $signed(h_key))) begin
			t_ent = h_rdata;
			t_pos = SW'(r_pos);
		end else if (state_q == S_DNR) begin
			t_ent = lft_q;
			t_pos = SW'(l_pos);
		end else begin
			t_ent = h_rdata;
			t_pos = SW'(l_pos);
		end
	end
	assign t_less = $signed(t_ent[KEY_W+DATA_W-1 -: KEY_W]) < $signed(cur_key_q);

	assign reply_go = !out_valid_q || !out_stall;

	always_comb begin
		h_we    = 1'b0;
		h_waddr = AW'(p_q - 1'b1);
		h_wdata = h_rdata;
		h_raddr = '0;
		m_we    = 1'b0;
		m_waddr = h_id;
		m_wdata = p_q;
		m_raddr = item_id;
		unique case (state_q)
			S_MAP:  h_raddr = AW'(m_rdata - 1'b1);
			S_CHK:  h_raddr = AW'(p_q - 1'b1);
			S_TAKE: begin
				m_we    = 1'b1;
				m_wdata = '0;
				h_raddr = AW'(count_q - 1'b1);
			end
			S_UP:   h_raddr = AW'((p_q >> 1) - 1'b1);
			S_UPC:  begin
				h_we = $signed(cur_key_q) < $signed(h_key);
				m_we = h_we;
			end
			S_DN:   h_raddr = AW'(l_pos - 1'b1);
			S_DNL:  begin
				h_raddr = AW'(r_pos - 1'b1);
				if (r_pos > (SW+1)'(count_q)) begin
					h_we    = t_less;
					m_we    = t_less;
					h_wdata = t_ent;
					m_waddr = t_ent[EW-1 -: ID_WIDTH];
				end
			end
			S_DNR:  begin
				h_we    = t_less;
				m_we    = t_less;
				h_wdata = t_ent;
				m_waddr = t_ent[EW-1 -: ID_WIDTH];
			end
			S_FIN:  begin
				h_we    = 1'b1;
				h_wdata = {cur_id_q, cur_key_q, cur_data_q};
				m_we    = 1'b1;
				m_waddr = cur_id_q;
			end
			default: ;
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign out_id    = out_id_q;
	assign out_key   = out_key_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			cap_q       <= CFG_W'(CAP_RESET);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (state_q == S_REPLY && reply_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q      <= req_type;
						id_q       <= item_id;
						key_q      <= item_key;
						data_q     <= item_data;
						res_st_q   <= ST_OK;
						res_id_q   <= '0;
						res_key_q  <= '0;
						res_data_q <= '0;
						p_q        <= SW'(1);
						unique case (req_type)
							REQ_INSERT: begin
								if (count_ext >= lim) begin
									res_st_q <= ST_FULL;
									state_q  <= S_REPLY;
								end else begin
									state_q <= S_MAP;
								end
							end
							REQ_POP: begin
								if (count_q == '0) begin
									res_st_q <= ST_EMPTY;
									state_q  <= S_REPLY;
								end else begin
									state_q <= S_TAKE;
								end
							end
							default: state_q <= S_MAP;
						endcase
					end
				end
				S_MAP: begin
					p_q <= m_rdata;
					if (map_ok) begin
						state_q <= S_CHK;
					end else if (req_q == REQ_INSERT) begin
						count_q    <= count_q + 1'b1;
						p_q        <= count_q + 1'b1;
						cur_id_q   <= id_q;
						cur_key_q  <= key_q;
						cur_data_q <= data_q;
						state_q    <= S_UP;
					end else begin
						res_st_q <= ST_NOT_FOUND;
						state_q  <= S_REPLY;
					end
				end
				S_CHK: begin
					unique case (req_q)
						REQ_INSERT: begin
							if (hit) begin
								res_st_q <= ST_EXISTS;
								state_q  <= S_REPLY;
							end else begin
								count_q    <= count_q + 1'b1;
								p_q        <= count_q + 1'b1;
								cur_id_q   <= id_q;
								cur_key_q  <= key_q;
								cur_data_q <= data_q;
								state_q    <= S_UP;
							end
						end
						REQ_CHANGE: begin
							if (!hit) begin
								res_st_q <= ST_NOT_FOUND;
								state_q  <= S_REPLY;
							end else begin
								cur_id_q   <= id_q;
								cur_key_q  <= key_q;
								cur_data_q <= h_data;
								state_q    <= ($signed(key_q) < $signed(h_key)) ? S_UP : S_DN;
							end
						end
						default: begin
							if (!hit) begin
								res_st_q <= ST_NOT_FOUND;
								state_q  <= S_REPLY;
							end else begin
								state_q <= S_TAKE;
							end
						end
					endcase
				end
				S_TAKE: begin
					res_id_q   <= h_id;
					res_key_q  <= h_key;
					res_data_q <= h_data;
					gone_key_q <= h_key;
					count_q    <= count_q - 1'b1;
					state_q    <= (p_q == count_q) ? S_REPLY : S_LAST;
				end
				S_LAST: begin
					cur_id_q   <= h_id;
					cur_key_q  <= h_key;
					cur_data_q <= h_data;
					state_q    <= ($signed(h_key) < $signed(gone_key_q)) ? S_UP : S_DN;
				end
				S_UP: begin
					state_q <= (p_q == SW'(1)) ? S_FIN : S_UPC;
				end
				S_UPC: begin
					if ($signed(cur_key_q) < $signed(h_key)) begin
						p_q     <= p_q >> 1;
						state_q <= S_UP;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_DN: begin
					state_q <= (l_pos > (SW+1)'(count_q)) ? S_FIN : S_DNL;
				end
				S_DNL: begin
					lft_q <= h_rdata;
					if (r_pos <= (SW+1)'(count_q)) begin
						state_q <= S_DNR;
					end else if (t_less) begin
						p_q     <= t_pos;
						state_q <= S_DN;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_DNR: begin
					if (t_less) begin
						p_q     <= t_pos;
						state_q <= S_DN;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: state_q <= S_REPLY;
				S_REPLY: begin
					if (reply_go) begin
						status_q    <= res_st_q;
						out_id_q    <= res_id_q;
						out_key_q   <= res_key_q;
						out_data_q  <= res_data_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- bench/indexed_min_heap_queue_core_tb.sv -----
// Self-checking bench for indexed_min_heap_queue_core: directed table, limit checks, then random requests.
// Depends on ihq_pkg and the core; results are checked against a heap predictor in the bench.
`timescale 1ns / 1ps
module indexed_min_heap_queue_core_tb;
	import ihq_pkg::*;

	localparam int SLOTS = 256;

	typedef struct packed {
		logic [1:0]  rq;
		logic [9:0]  id;
		logic [31:0] key;
		logic [31:0] data;
	} request_t;

	typedef struct packed {
		logic [2:0]  st;
		logic [9:0]  id;
		logic [31:0] key;
		logic [31:0] data;
	} answer_t;

	typedef struct {
		request_t req;
		logic     has_ans;
		answer_t  ans;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] req_type = '0;
	logic [9:0] item_id = '0;
	logic [31:0] item_key = '0;
	logic [31:0] item_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] status;
	logic [9:0] out_id;
	logic [31:0] out_key;
	logic [31:0] out_data;
	logic cfg_we = 1'b0;
	logic [8:0] cfg_wdata = '0;

	indexed_min_heap_queue_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .item_id(item_id), .item_key(item_key), .item_data(item_data),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .out_id(out_id), .out_key(out_key), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state
	logic [9:0]  h_id   [1:SLOTS];
	logic [31:0] h_key  [1:SLOTS];
	logic [31:0] h_data [1:SLOTS];
	int          slot_of [0:1023];
	int          count;
	logic [8:0]  cap_reg;

	answer_t awaited[$];
	int errors = 0;
	int n_sent = 0, n_got = 0, n_ok = 0;
	logic quiet = 1'b0;
	logic hold_long = 1'b0;

	function automatic int cap_now();
		int l;
		l = (cap_reg == 0) ? LIMIT_WHEN_ZERO : cap_reg;
		return (l > SLOTS) ? SLOTS : l;
	endfunction

	task automatic swap_slots(int a, int b);
		logic [9:0] ti;
		logic [31:0] tk, td;
		ti = h_id[a]; h_id[a] = h_id[b]; h_id[b] = ti;
		tk = h_key[a]; h_key[a] = h_key[b]; h_key[b] = tk;
		td = h_data[a]; h_data[a] = h_data[b]; h_data[b] = td;
		slot_of[h_id[a]] = a;
		slot_of[h_id[b]] = b;
	endtask

	task automatic sift_up(int p);
		while (p > 1 && $signed(h_key[p]) < $signed(h_key[p >> 1])) begin
			swap_slots(p, p >> 1);
			p = p >> 1;
		end
	endtask

	task automatic sift_down(int p);
		int l, t;
		while (2 * p <= count) begin
			l = 2 * p;
			t = (l + 1 > count || $signed(h_key[l]) < $signed(h_key[l + 1])) ? l : l + 1;
			if (!($signed(h_key[t]) < $signed(h_key[p])))
				break;
			swap_slots(p, t);
			p = t;
		end
	endtask

	function automatic int find_slot(logic [9:0] id);
		int s;
		s = slot_of[id];
		return (s == 0 || s > count) ? 0 : s;
	endfunction

	task automatic take_out(int p, inout answer_t a);
		logic [31:0] gone;
		int last;
		gone = h_key[p];
		last = count;
		a.id = h_id[p]; a.key = gone; a.data = h_data[p];
		slot_of[h_id[p]] = 0;
		count = last - 1;
		if (p != last) begin
			h_id[p] = h_id[last]; h_key[p] = h_key[last]; h_data[p] = h_data[last];
			slot_of[h_id[p]] = p;
			if ($signed(h_key[p]) < $signed(gone))
				sift_up(p);
			else
				sift_down(p);
		end
	endtask

	task automatic heap_step(request_t r, output answer_t a);
		int s;
		logic [31:0] old;
		a = '0;
		a.st = ST_OK;
		case (r.rq)
			REQ_INSERT: begin
				if (count >= cap_now())
					a.st = ST_FULL;
				else if (find_slot(r.id) != 0)
					a.st = ST_EXISTS;
				else begin
					count++;
					h_id[count] = r.id; h_key[count] = r.key; h_data[count] = r.data;
					slot_of[r.id] = count;
					sift_up(count);
				end
			end
			REQ_CHANGE: begin
				s = find_slot(r.id);
				if (s == 0)
					a.st = ST_NOT_FOUND;
				else begin
					old = h_key[s];
					h_key[s] = r.key;
					if ($signed(r.key) < $signed(old))
						sift_up(s);
					else
						sift_down(s);
				end
			end
			REQ_POP: begin
				if (count == 0)
					a.st = ST_EMPTY;
				else
					take_out(1, a);
			end
			default: begin
				s = find_slot(r.id);
				if (s == 0)
					a.st = ST_NOT_FOUND;
				else
					take_out(s, a);
			end
		endcase
	endtask

	// valid stays up after acceptance until the next request, an idle gap or drain() replaces it
	task automatic send(request_t r, logic has_fixed, answer_t fixed);
		int gap;
		answer_t a;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= r.rq; item_id <= r.id; item_key <= r.key; item_data <= r.data;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		heap_step(r, a);
		if (has_fixed && a !== fixed) begin
			$error("directed row: predictor gives %h, table gives %h", a, fixed);
			errors++;
		end
		awaited.push_back(a);
		n_sent++;
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (awaited.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (60) @(posedge clk);
	endtask

	task automatic set_cap(logic [8:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cap_reg = v;
		@(posedge clk);
	endtask

	// receiver
	always @(posedge clk) begin
		answer_t e;
		if (arst_n && out_valid && !out_stall) begin
			n_got++;
			if (awaited.size() == 0) begin
				$error("result with none awaited");
				errors++;
			end else begin
				e = awaited.pop_front();
				if (status !== e.st) begin
					$error("status: expected %0d, actual %0d", e.st, status); errors++;
				end
				if (out_id !== e.id) begin
					$error("out_id: expected %0d, actual %0d", e.id, out_id); errors++;
				end
				if (out_key !== e.key) begin
					$error("out_key: expected %h, actual %h", e.key, out_key); errors++;
				end
				if (out_data !== e.data) begin
					$error("out_data: expected %h, actual %h", e.data, out_data); errors++;
				end
				if (e.st == ST_OK)
					n_ok++;
			end
		end
	end

	// stall driver
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_long) begin
				out_stall <= 1'b1;
				n = 0;
				while (n < 400) begin
					@(posedge clk);
					n++;
				end
				out_stall <= 1'b0;
				wait (!hold_long);
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				out_stall <= 1'b0;
			end
			@(posedge clk);
		end
	end

	function automatic request_t mk(logic [1:0] q, logic [9:0] i, logic [31:0] k, logic [31:0] d);
		request_t r;
		r.rq = q; r.id = i; r.key = k; r.data = d;
		return r;
	endfunction

	function automatic answer_t ans(logic [2:0] s, logic [9:0] i, logic [31:0] k, logic [31:0] d);
		answer_t a;
		a.st = s; a.id = i; a.key = k; a.data = d;
		return a;
	endfunction

	initial begin
		row_t tbl[$];
		request_t r;
		answer_t none;
		int live_ids[$];
		int sel, idx;
		none = '0;
		for (int i = 0; i < 1024; i++) slot_of[i] = 0;
		count = 0;
		cap_reg = 9'(CAP_RESET);

		// directed rows
		tbl.push_back('{mk(REQ_POP, 10'd0, 32'd0, 32'd0), 1'b1, ans(ST_EMPTY, 0, 0, 0)});
		tbl.push_back('{mk(REQ_REMOVE, 10'd5, 32'd0, 32'd0), 1'b1, ans(ST_NOT_FOUND, 0, 0, 0)});
		tbl.push_back('{mk(REQ_CHANGE, 10'd0, 32'd7, 32'd0), 1'b1, ans(ST_NOT_FOUND, 0, 0, 0)});
		tbl.push_back('{mk(REQ_INSERT, 10'd1023, 32'h7FFFFFFF, 32'hFFFFFFFF), 1'b1, none});
		tbl.push_back('{mk(REQ_INSERT, 10'd1023, 32'd0, 32'd0), 1'b1, ans(ST_EXISTS, 0, 0, 0)});
		tbl.push_back('{mk(REQ_INSERT, 10'd0, 32'h80000000, 32'd0), 1'b1, none});
		tbl.push_back('{mk(REQ_INSERT, 10'd3, 32'd5, 32'hA5A5A5A5), 1'b0, none});
		tbl.push_back('{mk(REQ_INSERT, 10'd4, 32'd5, 32'h5A5A5A5A), 1'b0, none});
		tbl.push_back('{mk(REQ_INSERT, 10'd6, 32'hFFFFFFFF, 32'd1), 1'b0, none});
		tbl.push_back('{mk(REQ_CHANGE, 10'd3, 32'd5, 32'd0), 1'b0, none});
		tbl.push_back('{mk(REQ_CHANGE, 10'd1023, 32'h80000001, 32'd0), 1'b0, none});
		tbl.push_back('{mk(REQ_CHANGE, 10'd0, 32'd100, 32'd0), 1'b0, none});
		tbl.push_back('{mk(REQ_POP, 10'd0, 32'd0, 32'd0), 1'b1,
			ans(ST_OK, 10'd1023, 32'h80000001, 32'hFFFFFFFF)});
		tbl.push_back('{mk(REQ_REMOVE, 10'd4, 32'd0, 32'd0), 1'b0, none});
		tbl.push_back('{mk(REQ_REMOVE, 10'd4, 32'd0, 32'd0), 1'b1, ans(ST_NOT_FOUND, 0, 0, 0)});
		tbl.push_back('{mk(REQ_POP, 10'd0, 32'd0, 32'd0), 1'b0, none});
		tbl.push_back('{mk(REQ_POP, 10'd0, 32'd0, 32'd0), 1'b0, none});
		tbl.push_back('{mk(REQ_POP, 10'd0, 32'd0, 32'd0), 1'b0, none});
		tbl.push_back('{mk(REQ_POP, 10'd0, 32'd0, 32'd0), 1'b1, ans(ST_EMPTY, 0, 0, 0)});

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (tbl[i]) send(tbl[i].req, tbl[i].has_ans, tbl[i].ans);

		// limit of one: full, then pressure while refilling
		set_cap(9'd1);
		send(mk(REQ_INSERT, 10'd9, 32'd1, 32'd2), 1'b0, none);
		send(mk(REQ_INSERT, 10'd8, 32'd1, 32'd2), 1'b1, ans(ST_FULL, 0, 0, 0));
		set_cap(9'd0);
		hold_long = 1'b1;
		for (int i = 0; i < 40; i++)
			send(mk(REQ_INSERT, 10'(i + 100), $urandom, $urandom), 1'b0, none);
		hold_long = 1'b0;
		// below count: limit lowered under the current size
		set_cap(9'd3);
		send(mk(REQ_INSERT, 10'd500, 32'd0, 32'd0), 1'b1, ans(ST_FULL, 0, 0, 0));
		set_cap(9'h1FF);

		// random phases with several limits
		for (int ph = 0; ph < 5; ph++) begin
			if (ph == 1) set_cap(9'd256);
			if (ph == 2) set_cap(9'd4);
			if (ph == 3) set_cap(9'($urandom_range(1, 255)));
			if (ph == 4) begin
				set_cap(9'd256);
				quiet = 1'b1;
			end
			for (int n = 0; n < 200; n++) begin
				live_ids.delete();
				for (int s = 1; s <= count; s++) live_ids.push_back(h_id[s]);
				r.rq = 2'($urandom_range(0, 3));
				r.key = $urandom;
				r.data = $urandom;
				if ($urandom_range(0, 3) == 0)
					r.key = $urandom_range(0, 7);
				sel = $urandom_range(0, 9);
				if (live_ids.size() != 0 && sel < 7) begin
					idx = $urandom_range(0, live_ids.size() - 1);
					r.id = 10'(live_ids[idx]);
				end else
					r.id = 10'($urandom);
				if (r.rq == REQ_INSERT && sel < 7 && count > 0 && $urandom_range(0, 1))
					r.id = 10'($urandom);
				if (count > 150 && r.rq == REQ_INSERT)
					r.rq = REQ_POP;
				send(r, 1'b0, none);
			end
		end

		drain();
		$display("Ran %0d requests (%0d results, %0d ok) over limits 0, 1, 3, 4, 256, 511.",
			n_sent, n_got, n_ok);
		if (errors == 0 && awaited.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end
endmodule
